>>> rtl/smc_pkg.sv
`timescale 1ns / 1ps
package smc_pkg;

	localparam int unsigned MemDepthDef = 1024;
	localparam int unsigned AddrW = 10;
	localparam int unsigned WordW = 32;
	localparam int unsigned CfgIdxW = 2;

	localparam logic [1:0] KIND_WRITE = 2'd0;
	localparam logic [1:0] KIND_START = 2'd1;
	localparam logic [1:0] KIND_EXEC = 2'd2;

	localparam logic [1:0] CFG_START = 2'd0;
	localparam logic [1:0] CFG_BASE = 2'd1;
	localparam logic [1:0] CFG_STACK = 2'd2;

	localparam logic [1:0] FLT_NONE = 2'd0;
	localparam logic [1:0] FLT_OPCODE = 2'd1;
	localparam logic [1:0] FLT_DIV0 = 2'd2;

	localparam logic [31:0] OP_HALT = 32'd0;
	localparam logic [31:0] OP_PUSHA = 32'd1;
	localparam logic [31:0] OP_PUSHV = 32'd2;
	localparam logic [31:0] OP_PUSHC = 32'd3;
	localparam logic [31:0] OP_STORE = 32'd4;
	localparam logic [31:0] OP_NEG = 32'd5;
	localparam logic [31:0] OP_ADD = 32'd6;
	localparam logic [31:0] OP_SUB = 32'd7;
	localparam logic [31:0] OP_MUL = 32'd8;
	localparam logic [31:0] OP_DIV = 32'd9;
	localparam logic [31:0] OP_JMP = 32'd10;
	localparam logic [31:0] OP_JZ = 32'd11;
	localparam logic [31:0] OP_EQ = 32'd12;
	localparam logic [31:0] OP_NE = 32'd13;
	localparam logic [31:0] OP_GT = 32'd14;
	localparam logic [31:0] OP_LT = 32'd15;
	localparam logic [31:0] OP_NOT = 32'd16;
	localparam logic [31:0] OP_AND = 32'd17;
	localparam logic [31:0] OP_OR = 32'd18;
	localparam logic [31:0] OP_OUT = 32'd19;
	localparam logic [31:0] OP_LOAD = 32'd20;

	typedef enum logic [3:0] {
		ST_IDLE,
		ST_RD_OP,
		ST_RD_ARG,
		ST_RD_A,
		ST_RD_B,
		ST_RD_X,
		ST_EXEC,
		ST_DIV,
		ST_WRITE,
		ST_RESULT
	} state_t;

endpackage

>>> rtl/stack_machine_core_top.sv
`timescale 1ns / 1ps
// channel | signals                         | direction
// input   | valid ready kind address data   | in
// output  | out_valid out_value running fault, valid/ready for result | out
// config  | cfg_we cfg_idx cfg_wdata        | in
// A write, a start, an ignored word or an execute while stopped goes from acceptance
// through the write slot to the result state before the next acceptance.
// An instruction steps through the single memory read port (accept, opcode,
// operand, two stack words, extra read, execute, write, result).
// A divide by a nonzero divisor also runs the shift-subtract divider state.
// Reset clears pointers, config, outputs and running; data registers and memory are not cleared.
// Input ready is low from acceptance until the result word is taken.
module stack_machine_core_top (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        valid,
	output logic        ready,
	input  logic [1:0]  kind,
	input  logic [9:0]  address,
	input  logic signed [31:0] data,
	output logic        result_valid,
	input  logic        result_ready,
	output logic        out_valid,
	output logic signed [31:0] out_value,
	output logic        running,
	output logic [1:0]  fault,
	input  logic        cfg_we,
	input  logic [1:0]  cfg_idx,
	input  logic [9:0]  cfg_wdata
);
	localparam int unsigned MEM_DEPTH = smc_pkg::MemDepthDef;
	localparam int unsigned MA = $clog2(MEM_DEPTH);

	smc_pkg::state_t state_q, state_d;
	logic [31:0] mem [MEM_DEPTH];
	logic [31:0] rdata_q;
	logic [MA-1:0] raddr, waddr;
	logic          we;
	logic [31:0]   wdata;

	logic [9:0] cfg_start_q, cfg_base_q, cfg_stack_q;
	logic [MA-1:0] ip_q, fb_q, sp_q;
	logic run_q;
	logic [1:0] kind_q;
	logic [MA-1:0] addr_q;
	logic [31:0] data_q, op_q, arg_q, a_q, b_q, r_q;
	logic [5:0] cnt_q;
	logic [31:0] rem_q, quo_q, dvs_q;
	logic neg_q;
	logic ov_q;
	logic [31:0] oval_q;
	logic [1:0] flt_q;
	logic [MA-1:0] sp_m1;
	logic [32:0] trial;
	logic is_write_op;

	assign sp_m1 = sp_q - 1'b1;
	assign trial = {rem_q, quo_q[31]} - {1'b0, dvs_q};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_start_q <= '0;
			cfg_base_q <= '0;
			cfg_stack_q <= '0;
		end else if (cfg_we) begin
			case (cfg_idx)
				smc_pkg::CFG_START: cfg_start_q <= cfg_wdata;
				smc_pkg::CFG_BASE: cfg_base_q <= cfg_wdata;
				smc_pkg::CFG_STACK: cfg_stack_q <= cfg_wdata;
				default: ;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (we) mem[waddr] <= wdata;
		rdata_q <= mem[raddr];
	end

	always_comb begin
		raddr = ip_q;
		case (state_q)
			smc_pkg::ST_RD_OP: raddr = ip_q;
			smc_pkg::ST_RD_ARG: raddr = ip_q + 1'b1;
			smc_pkg::ST_RD_A: raddr = sp_m1;
			smc_pkg::ST_RD_B: raddr = sp_q;
			smc_pkg::ST_RD_X: raddr = (op_q == smc_pkg::OP_PUSHV) ?
				(fb_q + arg_q[MA-1:0]) : rdata_q[MA-1:0];
			default: raddr = ip_q;
		endcase
	end

	always_comb begin
		state_d = state_q;
		case (state_q)
			smc_pkg::ST_IDLE: if (valid) begin
				state_d = (kind == smc_pkg::KIND_EXEC && run_q) ? smc_pkg::ST_RD_OP :
					smc_pkg::ST_WRITE;
			end
			smc_pkg::ST_RD_OP: state_d = smc_pkg::ST_RD_ARG;
			smc_pkg::ST_RD_ARG: state_d = smc_pkg::ST_RD_A;
			smc_pkg::ST_RD_A: state_d = smc_pkg::ST_RD_B;
			smc_pkg::ST_RD_B: state_d = smc_pkg::ST_RD_X;
			smc_pkg::ST_RD_X: state_d = smc_pkg::ST_EXEC;
			smc_pkg::ST_EXEC: state_d = (op_q == smc_pkg::OP_DIV && b_q != 0) ?
				smc_pkg::ST_DIV : smc_pkg::ST_WRITE;
			smc_pkg::ST_DIV: if (cnt_q == 6'd32) state_d = smc_pkg::ST_WRITE;
			smc_pkg::ST_WRITE: state_d = smc_pkg::ST_RESULT;
			smc_pkg::ST_RESULT: if (result_ready) state_d = smc_pkg::ST_IDLE;
			default: state_d = smc_pkg::ST_IDLE;
		endcase
	end

	always_comb begin
		ready = (state_q == smc_pkg::ST_IDLE);
		result_valid = (state_q == smc_pkg::ST_RESULT);
		out_valid = ov_q;
		out_value = oval_q;
		running = run_q;
		fault = flt_q;
	end

	always_comb begin
		is_write_op = 1'b0;
		waddr = sp_q;
		wdata = r_q;
		case (op_q)
			smc_pkg::OP_PUSHA, smc_pkg::OP_PUSHV, smc_pkg::OP_PUSHC: begin
				is_write_op = 1'b1;
			end
			smc_pkg::OP_STORE: begin
				is_write_op = 1'b1;
				waddr = a_q[MA-1:0];
			end
			smc_pkg::OP_NEG, smc_pkg::OP_NOT, smc_pkg::OP_LOAD: is_write_op = 1'b1;
			smc_pkg::OP_ADD, smc_pkg::OP_SUB, smc_pkg::OP_MUL, smc_pkg::OP_EQ,
			smc_pkg::OP_NE, smc_pkg::OP_GT, smc_pkg::OP_LT, smc_pkg::OP_AND,
			smc_pkg::OP_OR, smc_pkg::OP_DIV: begin
				is_write_op = 1'b1;
			end
			default: is_write_op = 1'b0;
		endcase
		we = 1'b0;
		if (state_q == smc_pkg::ST_WRITE) begin
			if (kind_q == smc_pkg::KIND_WRITE) begin
				we = 1'b1;
				waddr = addr_q;
				wdata = data_q;
			end else if (kind_q == smc_pkg::KIND_EXEC && run_q && flt_q == smc_pkg::FLT_NONE) begin
				we = is_write_op;
			end
		end
	end

	always_ff @(posedge clk) begin
		case (state_q)
			smc_pkg::ST_IDLE: if (valid) begin
				kind_q <= kind;
				addr_q <= address[MA-1:0];
				data_q <= data;
			end
			smc_pkg::ST_RD_ARG: op_q <= rdata_q;
			smc_pkg::ST_RD_A: arg_q <= rdata_q;
			smc_pkg::ST_RD_B: a_q <= rdata_q;
			smc_pkg::ST_RD_X: b_q <= rdata_q;
			smc_pkg::ST_EXEC: begin
				case (op_q)
					smc_pkg::OP_PUSHA: r_q <= {{(32-MA){1'b0}}, fb_q + arg_q[MA-1:0]};
					smc_pkg::OP_PUSHV, smc_pkg::OP_LOAD: r_q <= rdata_q;
					smc_pkg::OP_PUSHC: r_q <= arg_q;
					smc_pkg::OP_STORE: r_q <= b_q;
					smc_pkg::OP_NEG: r_q <= 32'd0 - b_q;
					smc_pkg::OP_ADD: r_q <= a_q + b_q;
					smc_pkg::OP_SUB: r_q <= a_q - b_q;
					smc_pkg::OP_MUL: r_q <= a_q * b_q;
					smc_pkg::OP_EQ: r_q <= {31'd0, a_q == b_q};
					smc_pkg::OP_NE: r_q <= {31'd0, a_q != b_q};
					smc_pkg::OP_GT: r_q <= {31'd0, $signed(a_q) > $signed(b_q)};
					smc_pkg::OP_LT: r_q <= {31'd0, $signed(a_q) < $signed(b_q)};
					smc_pkg::OP_NOT: r_q <= {31'd0, b_q == 0};
					smc_pkg::OP_AND: r_q <= {31'd0, a_q != 0 && b_q != 0};
					smc_pkg::OP_OR: r_q <= {31'd0, a_q != 0 || b_q != 0};
					default: r_q <= b_q;
				endcase
				quo_q <= a_q[31] ? 32'd0 - a_q : a_q;
				dvs_q <= b_q[31] ? 32'd0 - b_q : b_q;
				rem_q <= '0;
				neg_q <= a_q[31] ^ b_q[31];
			end
			smc_pkg::ST_DIV: begin
				if (cnt_q == 6'd32) begin
					r_q <= neg_q ? 32'd0 - quo_q : quo_q;
				end else if (!trial[32]) begin
					rem_q <= trial[31:0];
					quo_q <= {quo_q[30:0], 1'b1};
				end else begin
					rem_q <= {rem_q[30:0], quo_q[31]};
					quo_q <= {quo_q[30:0], 1'b0};
				end
			end
			default: ;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= smc_pkg::ST_IDLE;
			ip_q <= '0;
			fb_q <= '0;
			sp_q <= '0;
			run_q <= 1'b0;
			cnt_q <= '0;
			ov_q <= 1'b0;
			oval_q <= '0;
			flt_q <= smc_pkg::FLT_NONE;
		end else begin
			state_q <= state_d;
			if (state_q == smc_pkg::ST_DIV) cnt_q <= cnt_q + 1'b1;
			else cnt_q <= '0;
			if (state_q == smc_pkg::ST_IDLE && valid) begin
				ov_q <= 1'b0;
				oval_q <= '0;
				flt_q <= smc_pkg::FLT_NONE;
			end
			if (state_q == smc_pkg::ST_EXEC) begin
				case (op_q)
					smc_pkg::OP_HALT: run_q <= 1'b0;
					smc_pkg::OP_PUSHA, smc_pkg::OP_PUSHV, smc_pkg::OP_PUSHC: begin
						sp_q <= sp_q + 1'b1;
						ip_q <= ip_q + 2'd2;
					end
					smc_pkg::OP_STORE: begin
						sp_q <= sp_q - 2'd2;
						ip_q <= ip_q + 1'b1;
					end
					smc_pkg::OP_NEG, smc_pkg::OP_NOT, smc_pkg::OP_LOAD: ip_q <= ip_q + 1'b1;
					smc_pkg::OP_ADD, smc_pkg::OP_SUB, smc_pkg::OP_MUL, smc_pkg::OP_EQ,
					smc_pkg::OP_NE, smc_pkg::OP_GT, smc_pkg::OP_LT, smc_pkg::OP_AND,
					smc_pkg::OP_OR: begin
						sp_q <= sp_m1;
						ip_q <= ip_q + 1'b1;
					end
					smc_pkg::OP_DIV: begin
						if (b_q == 0) begin
							run_q <= 1'b0;
							flt_q <= smc_pkg::FLT_DIV0;
						end else begin
							sp_q <= sp_m1;
							ip_q <= ip_q + 1'b1;
						end
					end
					smc_pkg::OP_JMP: ip_q <= ip_q + arg_q[MA-1:0];
					smc_pkg::OP_JZ: begin
						sp_q <= sp_m1;
						ip_q <= ip_q + ((b_q == 0) ? arg_q[MA-1:0] : MA'(2));
					end
					smc_pkg::OP_OUT: begin
						ov_q <= 1'b1;
						oval_q <= b_q;
						sp_q <= sp_m1;
						ip_q <= ip_q + 1'b1;
					end
					default: begin
						run_q <= 1'b0;
						flt_q <= smc_pkg::FLT_OPCODE;
					end
				endcase
			end
			if (state_q == smc_pkg::ST_WRITE && kind_q == smc_pkg::KIND_START) begin
				ip_q <= cfg_start_q[MA-1:0];
				fb_q <= cfg_base_q[MA-1:0];
				sp_q <= cfg_stack_q[MA-1:0];
				run_q <= 1'b1;
			end
		end
	end

	// MEM_DEPTH must equal 2**MA for pointer wrap by truncation; config is 10 bits.

	a_div_len: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == smc_pkg::ST_DIV) |-> (cnt_q <= 6'd32))
		else $error("divide count overrun");
	a_fault_stops: assert property (@(posedge clk) disable iff (!arst_n)
		(result_valid && fault != smc_pkg::FLT_NONE) |-> !running)
		else $error("fault left machine running");
	a_out_nofault: assert property (@(posedge clk) disable iff (!arst_n)
		(result_valid && out_valid) |-> (fault == smc_pkg::FLT_NONE))
		else $error("output with fault");
	a_busy: assert property (@(posedge clk) disable iff (!arst_n)
		(valid && ready) |=> !ready)
		else $error("ready while busy");

endmodule

>>> tb/tb.sv
`timescale 1ns / 1ps
module tb;

	localparam logic [1:0] KIND_NONE = 2'd3;
	localparam int unsigned CycleLimit = 3000000;

	typedef struct packed {
		logic [1:0]  kind;
		logic [9:0]  address;
		logic [31:0] data;
	} word_t;

	typedef struct packed {
		logic        ov;
		logic [31:0] oval;
		logic        run;
		logic [1:0]  flt;
	} res_t;

	logic clk;
	logic arst_n;
	logic valid;
	logic ready;
	logic [1:0] kind;
	logic [9:0] address;
	logic signed [31:0] data;
	logic result_valid;
	logic result_ready;
	logic out_valid;
	logic signed [31:0] out_value;
	logic running;
	logic [1:0] fault;
	logic cfg_we;
	logic [1:0] cfg_idx;
	logic [9:0] cfg_wdata;

	stack_machine_core_top DUT (
		.clk(clk), .arst_n(arst_n), .valid(valid), .ready(ready), .kind(kind),
		.address(address), .data(data), .result_valid(result_valid),
		.result_ready(result_ready), .out_valid(out_valid), .out_value(out_value),
		.running(running), .fault(fault), .cfg_we(cfg_we), .cfg_idx(cfg_idx),
		.cfg_wdata(cfg_wdata)
	);

	// machine shadow
	logic [31:0] mem_sh [1024];
	logic [9:0] ip_sh, fb_sh, sp_sh;
	logic run_sh;
	logic [9:0] sa_cfg, ba_cfg, st_cfg;

	word_t pend_words[$];
	res_t exp_results[$];
	int errors;
	int cycles;
	int n_checked, n_outputs, n_faults;
	logic took;
	int burst_left, gap_left, send_mode, stall_mode;

	always begin
		clk = 1'b1;
		#5;
		clk = 1'b0;
		#5;
	end

	function automatic logic [31:0] sdiv(input logic [31:0] a, input logic [31:0] b);
		logic [31:0] ma, mb, q;
		ma = a[31] ? -a : a;
		mb = b[31] ? -b : b;
		q = ma / mb;
		return (a[31] != b[31]) ? -q : q;
	endfunction

	task automatic step_machine(input word_t w, output res_t r);
		logic [9:0] p, s, s1;
		logic [31:0] op, arg, a, b, v;
		r = '0;
		if (w.kind == smc_pkg::KIND_WRITE) begin
			mem_sh[w.address] = w.data;
		end else if (w.kind == smc_pkg::KIND_START) begin
			ip_sh = sa_cfg;
			fb_sh = ba_cfg;
			sp_sh = st_cfg;
			run_sh = 1'b1;
		end else if (w.kind == smc_pkg::KIND_EXEC && run_sh) begin
			p = ip_sh;
			s = sp_sh;
			s1 = s - 10'd1;
			op = mem_sh[p];
			arg = mem_sh[p + 10'd1];
			a = mem_sh[s1];
			b = mem_sh[s];
			v = '0;
			case (op)
				smc_pkg::OP_HALT: run_sh = 1'b0;
				smc_pkg::OP_PUSHA: begin
					s = s + 10'd1;
					v = {22'd0, fb_sh + arg[9:0]};
					mem_sh[s] = v;
					p = p + 10'd2;
				end
				smc_pkg::OP_PUSHV: begin
					s = s + 10'd1;
					mem_sh[s] = mem_sh[fb_sh + arg[9:0]];
					p = p + 10'd2;
				end
				smc_pkg::OP_PUSHC: begin
					s = s + 10'd1;
					mem_sh[s] = arg;
					p = p + 10'd2;
				end
				smc_pkg::OP_STORE: begin
					mem_sh[a[9:0]] = b;
					s = s - 10'd2;
					p = p + 10'd1;
				end
				smc_pkg::OP_NEG: begin
					mem_sh[s] = -b;
					p = p + 10'd1;
				end
				smc_pkg::OP_ADD, smc_pkg::OP_SUB, smc_pkg::OP_MUL, smc_pkg::OP_EQ,
				smc_pkg::OP_NE, smc_pkg::OP_GT, smc_pkg::OP_LT, smc_pkg::OP_AND,
				smc_pkg::OP_OR: begin
					case (op)
						smc_pkg::OP_ADD: v = a + b;
						smc_pkg::OP_SUB: v = a - b;
						smc_pkg::OP_MUL: v = a * b;
						smc_pkg::OP_EQ: v = {31'd0, a == b};
						smc_pkg::OP_NE: v = {31'd0, a != b};
						smc_pkg::OP_GT: v = {31'd0, $signed(a) > $signed(b)};
						smc_pkg::OP_LT: v = {31'd0, $signed(a) < $signed(b)};
						smc_pkg::OP_AND: v = {31'd0, (a != 0) && (b != 0)};
						default: v = {31'd0, (a != 0) || (b != 0)};
					endcase
					mem_sh[s1] = v;
					s = s1;
					p = p + 10'd1;
				end
				smc_pkg::OP_DIV: begin
					if (b == 0) begin
						run_sh = 1'b0;
						r.flt = smc_pkg::FLT_DIV0;
					end else begin
						mem_sh[s1] = sdiv(a, b);
						s = s1;
						p = p + 10'd1;
					end
				end
				smc_pkg::OP_JMP: p = p + arg[9:0];
				smc_pkg::OP_JZ: begin
					s = s1;
					p = p + ((b == 0) ? arg[9:0] : 10'd2);
				end
				smc_pkg::OP_NOT: begin
					mem_sh[s] = (b == 0) ? 32'd1 : 32'd0;
					p = p + 10'd1;
				end
				smc_pkg::OP_OUT: begin
					r.ov = 1'b1;
					r.oval = b;
					s = s1;
					p = p + 10'd1;
				end
				smc_pkg::OP_LOAD: begin
					mem_sh[s] = mem_sh[b[9:0]];
					p = p + 10'd1;
				end
				default: begin
					run_sh = 1'b0;
					r.flt = smc_pkg::FLT_OPCODE;
				end
			endcase
			ip_sh = p;
			sp_sh = s;
		end
		r.run = run_sh;
	endtask

	// input acceptance and result checking
	always @(posedge clk) begin
		word_t w;
		res_t r, e;
		took <= valid && ready && arst_n;
		cycles <= cycles + 1;
		if (arst_n && valid && ready) begin
			w.kind = kind;
			w.address = address;
			w.data = data;
			step_machine(w, r);
			exp_results.push_back(r);
		end
		if (arst_n && result_valid && result_ready) begin
			if (exp_results.size() == 0) begin
				$error("result word with nothing expected");
				errors <= errors + 1;
			end else begin
				e = exp_results.pop_front();
				n_checked <= n_checked + 1;
				if (e.ov) n_outputs <= n_outputs + 1;
				if (e.flt != smc_pkg::FLT_NONE) n_faults <= n_faults + 1;
				if (out_valid !== e.ov) begin
					$error("out_valid expected %0d actual %0d", e.ov, out_valid);
					errors <= errors + 1;
				end
				if (out_value !== e.oval) begin
					$error("out_value expected %0d actual %0d", $signed(e.oval), out_value);
					errors <= errors + 1;
				end
				if (running !== e.run) begin
					$error("running expected %0d actual %0d", e.run, running);
					errors <= errors + 1;
				end
				if (fault !== e.flt) begin
					$error("fault expected %0d actual %0d", e.flt, fault);
					errors <= errors + 1;
				end
			end
		end
	end

	always @(posedge clk) begin
		if (cycles > CycleLimit) begin
			$display("timeout after %0d cycles", cycles);
			$display("Mismatches found");
			$finish;
		end
	end

	// sender: bursts and gaps
	always @(negedge clk) begin
		logic nv;
		word_t w;
		if (arst_n) begin
			nv = valid && !took;
			if (!nv) begin
				if (gap_left > 0) begin
					gap_left--;
				end else if (pend_words.size() > 0) begin
					w = pend_words.pop_front();
					kind <= w.kind;
					address <= w.address;
					data <= w.data;
					nv = 1'b1;
					if (burst_left <= 0) begin
						burst_left = $urandom_range(1, 12);
						send_mode = $urandom_range(0, 2);
					end
					burst_left--;
					if (burst_left == 0)
						gap_left = (send_mode == 0) ? 0 : $urandom_range(1, 8);
				end
			end
			valid <= nv;
		end
	end

	// receiver: stall pattern drawn at random from four modes
	always @(negedge clk) begin
		if (cycles % 50 == 0) stall_mode = $urandom_range(0, 3);
		case (stall_mode)
			0: result_ready <= 1'b1;
			1: result_ready <= ($urandom_range(0, 1) == 1);
			2: result_ready <= ($urandom_range(0, 3) == 0);
			default: result_ready <= ((cycles / 7) % 2 == 0);
		endcase
	end

	task automatic put(input logic [1:0] k, input logic [9:0] a, input logic [31:0] d);
		word_t w;
		w.kind = k;
		w.address = a;
		w.data = d;
		pend_words.push_back(w);
	endtask

	task automatic drain();
		while (pend_words.size() > 0 || exp_results.size() > 0 || valid)
			@(posedge clk);
		repeat (4) @(negedge clk);
	endtask

	task automatic set_reg(input logic [1:0] idx, input logic [9:0] v);
		drain();
		cfg_we <= 1'b1;
		cfg_idx <= idx;
		cfg_wdata <= v;
		@(negedge clk);
		cfg_we <= 1'b0;
		case (idx)
			smc_pkg::CFG_START: sa_cfg = v;
			smc_pkg::CFG_BASE: ba_cfg = v;
			default: st_cfg = v;
		endcase
	endtask

	function automatic logic [31:0] rand_value();
		case ($urandom_range(0, 5))
			0: return 32'h8000_0000;
			1: return 32'h7FFF_FFFF;
			2: return 32'hFFFF_FFFF;
			3: return 32'd0;
			4: return $urandom_range(0, 9);
			default: return $urandom;
		endcase
	endfunction

	// write a program of n_ins random instructions starting at pa
	task automatic load_program(input logic [9:0] pa, input int n_ins);
		logic [9:0] a;
		logic [31:0] op;
		int sel;
		a = pa;
		for (int i = 0; i < n_ins; i++) begin
			sel = $urandom_range(0, 99);
			if (sel < 35) op = smc_pkg::OP_PUSHC;
			else if (sel < 40) op = smc_pkg::OP_PUSHA;
			else if (sel < 45) op = smc_pkg::OP_PUSHV;
			else if (sel < 48) op = smc_pkg::OP_JMP;
			else if (sel < 53) op = smc_pkg::OP_JZ;
			else if (sel < 55) op = smc_pkg::OP_HALT;
			else if (sel < 57) op = $urandom_range(21, 40);
			else if (sel < 58) op = $urandom;
			else op = $urandom_range(smc_pkg::OP_STORE, smc_pkg::OP_LOAD);
			put(smc_pkg::KIND_WRITE, a, op);
			a = a + 10'd1;
			if (op == smc_pkg::OP_PUSHC) begin
				put(smc_pkg::KIND_WRITE, a, rand_value());
				a = a + 10'd1;
			end else if (op == smc_pkg::OP_PUSHA || op == smc_pkg::OP_PUSHV) begin
				put(smc_pkg::KIND_WRITE, a, $urandom);
				a = a + 10'd1;
			end else if (op == smc_pkg::OP_JMP || op == smc_pkg::OP_JZ) begin
				put(smc_pkg::KIND_WRITE, a, $urandom_range(0, 12) - 6);
				a = a + 10'd1;
			end
		end
	endtask

	initial begin
		int n_items;
		logic [9:0] pa;
		arst_n = 1'b0;
		valid = 1'b0;
		kind = smc_pkg::KIND_WRITE;
		address = '0;
		data = '0;
		result_ready = 1'b0;
		cfg_we = 1'b0;
		cfg_idx = smc_pkg::CFG_START;
		cfg_wdata = '0;
		errors = 0;
		cycles = 0;
		n_checked = 0;
		n_outputs = 0;
		n_faults = 0;
		burst_left = 0;
		gap_left = 0;
		send_mode = 0;
		stall_mode = 0;
		ip_sh = '0;
		fb_sh = '0;
		sp_sh = '0;
		run_sh = 1'b0;
		sa_cfg = '0;
		ba_cfg = '0;
		st_cfg = '0;
		repeat (7) @(negedge clk);
		arst_n = 1'b1;

		// fill every word so that no read ever sees an unwritten word
		for (int i = 0; i < 1024; i++)
			put(smc_pkg::KIND_WRITE, i[9:0], $urandom);

		// directed: execute while stopped, ignored word, wrapping program, overflow divide, divide by zero, restarts
		set_reg(smc_pkg::CFG_START, 10'd1021);
		set_reg(smc_pkg::CFG_BASE, 10'd1023);
		set_reg(smc_pkg::CFG_STACK, 10'd500);
		put(smc_pkg::KIND_EXEC, 10'd0, 32'd0);
		put(KIND_NONE, 10'h3FF, 32'hFFFF_FFFF);
		put(smc_pkg::KIND_WRITE, 10'd1021, smc_pkg::OP_PUSHC);
		put(smc_pkg::KIND_WRITE, 10'd1022, 32'h8000_0000);
		put(smc_pkg::KIND_WRITE, 10'd1023, smc_pkg::OP_PUSHC);
		put(smc_pkg::KIND_WRITE, 10'd0, 32'hFFFF_FFFF);
		put(smc_pkg::KIND_WRITE, 10'd1, smc_pkg::OP_DIV);
		put(smc_pkg::KIND_WRITE, 10'd2, smc_pkg::OP_OUT);
		put(smc_pkg::KIND_WRITE, 10'd3, smc_pkg::OP_PUSHC);
		put(smc_pkg::KIND_WRITE, 10'd4, 32'd0);
		put(smc_pkg::KIND_WRITE, 10'd5, smc_pkg::OP_DIV);
		put(smc_pkg::KIND_START, 10'd0, 32'd0);
		repeat (6) put(smc_pkg::KIND_EXEC, 10'd0, 32'd0);
		put(smc_pkg::KIND_EXEC, 10'd0, 32'd0);
		put(smc_pkg::KIND_WRITE, 10'd6, 32'd21);
		put(smc_pkg::KIND_WRITE, 10'd7, smc_pkg::OP_HALT);
		put(smc_pkg::KIND_START, 10'd0, 32'd0);
		put(smc_pkg::KIND_START, 10'd0, 32'd0);
		set_reg(smc_pkg::CFG_START, 10'd6);
		put(smc_pkg::KIND_START, 10'd0, 32'd0);
		put(smc_pkg::KIND_EXEC, 10'd0, 32'd0);
		set_reg(smc_pkg::CFG_START, 10'd7);
		put(smc_pkg::KIND_START, 10'd0, 32'd0);
		put(smc_pkg::KIND_EXEC, 10'd0, 32'd0);

		// random programs, one per phase
		n_items = 0;
		while (n_items < 700) begin
			case ($urandom_range(0, 4))
				0: pa = 10'd0;
				1: pa = 10'd1016;
				default: pa = 10'($urandom);
			endcase
			set_reg(smc_pkg::CFG_START, pa);
			set_reg(smc_pkg::CFG_BASE, ($urandom_range(0, 3) == 0) ? 10'h3FF : 10'($urandom));
			set_reg(smc_pkg::CFG_STACK, ($urandom_range(0, 3) == 0) ? 10'd0 : 10'($urandom));
			load_program(pa, $urandom_range(6, 16));
			put(smc_pkg::KIND_START, 10'd0, 32'd0);
			for (int i = 0; i < 30; i++) begin
				case ($urandom_range(0, 19))
					0: put(KIND_NONE, 10'($urandom), $urandom);
					1: put(smc_pkg::KIND_WRITE, 10'($urandom), $urandom);
					2: if ($urandom_range(0, 3) == 0)
						put(smc_pkg::KIND_START, 10'($urandom), $urandom);
					default: put(smc_pkg::KIND_EXEC, 10'($urandom), $urandom);
				endcase
			end
			n_items += 60;
		end

		drain();
		repeat (60) @(posedge clk);
		$display("checked %0d result words, %0d outputs and %0d faults", n_checked,
			n_outputs, n_faults);
		if (errors == 0 && exp_results.size() == 0) begin
			$display("No mismatches found");
		end else begin
			$display("Mismatches found");
		end
		$finish;
	end

endmodule
